// ----- rtl/pd_pkg.sv -----
// Package for the percent decoder: command type, held-state codes, hex helpers.
// No dependencies; every rtl module imports it.
`timescale 1ns / 1ps
`default_nettype none

package pd_pkg;

   localparam logic [7:0] PCT_CHAR  = 8'h25;
   localparam int         CMD_DEPTH = 2;

   // held state codes
   localparam logic [1:0] HELD_NONE  = 2'd0;
   localparam logic [1:0] HELD_PCT   = 2'd1;
   localparam logic [1:0] HELD_DIGIT = 2'd2;

   // one command: up to three output bytes, last flag goes on the final one
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
      logic            last;
   } cmd_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         t = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         t = c - 8'h61 + 8'd10;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         t = c - 8'h41 + 8'd10;
      end
      nibble_of = t[3:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/pd_front.sv -----
// Front part of the percent decoder: takes raw bytes, tracks the held '%'
// and digit, and builds at most one command per byte. Depends on pd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pd_front (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic [7:0]     in_byte,
   input  wire logic           in_last,
   output pd_pkg::cmd_type     cmd,
   output logic                cmd_valid
);
   import pd_pkg::*;

   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held_digit_ff, held_digit_in;
   cmd_type    cmd_c;
   logic       fresh;
   logic       b_hex;

   assign b_hex = is_hex(in_byte);

   always_comb begin
      cmd_c         = '0;
      cmd_c.last    = in_last;
      held_count_in = HELD_NONE;
      held_digit_in = 8'h00;
      fresh         = 1'b0;
      unique case (held_count_ff)
         HELD_PCT: begin
            if (b_hex && !in_last) begin
               held_count_in = HELD_DIGIT;
               held_digit_in = in_byte;
            end else begin
               cmd_c.bytes[0] = PCT_CHAR;
               cmd_c.count    = 2'd1;
               fresh          = 1'b1;
            end
         end
         HELD_DIGIT: begin
            if (b_hex && is_hex(held_digit_ff)) begin
               cmd_c.bytes[0] = {nibble_of(held_digit_ff), nibble_of(in_byte)};
               cmd_c.count    = 2'd1;
            end else begin
               cmd_c.bytes[0] = PCT_CHAR;
               cmd_c.bytes[1] = held_digit_ff;
               cmd_c.count    = 2'd2;
               fresh          = 1'b1;
            end
         end
         default: fresh = 1'b1;
      endcase
      // examine the byte again with nothing held
      if (fresh) begin
         if (in_byte == PCT_CHAR && !in_last) begin
            held_count_in = HELD_PCT;
         end else begin
            cmd_c.bytes[cmd_c.count] = in_byte;
            cmd_c.count              = cmd_c.count + 2'd1;
         end
      end
   end

   assign cmd       = cmd_c;
   assign cmd_valid = accept && (cmd_c.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= HELD_NONE;
         held_digit_ff <= 8'h00;
      end else if (accept) begin
         held_count_ff <= held_count_in;
         held_digit_ff <= held_digit_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pd_cmd_queue.sv -----
// Short command queue between front and back parts of the percent decoder.
// Depends on pd_pkg for cmd_type and CMD_DEPTH.
`timescale 1ns / 1ps
`default_nettype none

module pd_cmd_queue (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           wr_en,
   input  wire pd_pkg::cmd_type wr_cmd,
   output logic                full,
   input  wire logic           rd_en,
   output pd_pkg::cmd_type     head,
   output logic                empty
);
   import pd_pkg::*;

   localparam int PtrW = $clog2(CMD_DEPTH);
   localparam int CntW = $clog2(CMD_DEPTH + 1);

   cmd_type              mem [CMD_DEPTH];
   logic [PtrW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]      count_ff;

   assign full  = (count_ff == CntW'(CMD_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CntW'(wr_en) - CntW'(rd_en);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!full || rd_en)) else $error("command queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty) else $error("command queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(CMD_DEPTH)) else $error("command queue count out of range");
   a_nonempty_cmd: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_cmd.count != 2'd0) else $error("empty command queued");

endmodule

`default_nettype wire

// ----- rtl/pd_back.sv -----
// Back part of the percent decoder: walks the head command one byte per
// beat and retires it after its final byte. Depends on pd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pd_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire pd_pkg::cmd_type head,
   input  wire logic           head_empty,
   output logic                head_pop,
   output logic [7:0]          out_byte,
   output logic                out_last,
   input  wire logic           out_pop
);
   import pd_pkg::*;

   logic [1:0] idx_ff;
   logic       at_end;

   assign at_end   = (idx_ff == head.count - 2'd1);
   assign out_byte = head.bytes[idx_ff];
   assign out_last = head.last && at_end;
   assign head_pop = out_pop && !head_empty && at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else if (out_pop && !head_empty) begin
         idx_ff <= at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   a_idx_in_cmd: assert property (@(posedge clock) disable iff (reset)
      !head_empty |-> idx_ff < head.count) else $error("byte index past command");
   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      head_empty |-> idx_ff == 2'd0) else $error("byte index held with no command");

endmodule

`default_nettype wire

// ----- rtl/percent_decoder_unit.sv -----
// Top level of the URL percent decoder: front classifier, command queue,
// back serializer. Depends on pd_pkg, pd_front, pd_cmd_queue, pd_back.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  Input channel: drive req_byte/req_last and raise push; a beat is taken at
//  a clock edge with push high and full low. Mark the final byte of each
//  string with req_last.
//  Result channel: while empty is low, rsp_byte/rsp_last show the oldest
//  decoded byte; raise pop to take it. rsp_last marks the string's final byte.
//  A beat's command is registered in the queue at the edge that takes it.
//  Throughput: one input beat per cycle while each byte yields at most one
//  result and the receiver pops every cycle. A byte that breaks an escape
//  yields up to three results, which leave one per cycle with pop high; the
//  two-entry command queue absorbs that and full rises only when it fills.
//  A held '%' or digit yields no result until the pattern resolves.
//  Receiver stall: results wait in the queue; full rises after two commands
//  are waiting, and input beats resume as soon as one retires.
//  Reset: clears the held '%' and digit and empties the queue.
module percent_decoder_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] req_byte,
   input  wire logic       req_last,
   input  wire logic       push,
   output logic            full,
   output logic [7:0]      rsp_byte,
   output logic            rsp_last,
   output logic            empty,
   input  wire logic       pop
);
   import pd_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    front_valid;
   logic    head_pop;
   logic    accept;

   // take a beat only when the queue has room for its command
   assign accept = push && !full;

   pd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_byte),
      .in_last   (req_last),
      .cmd       (front_cmd),
      .cmd_valid (front_valid)
   );

   pd_cmd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (front_valid),
      .wr_cmd (front_cmd),
      .full   (full),
      .rd_en  (head_pop),
      .head   (head_cmd),
      .empty  (empty)
   );

   // advance through the head command one byte per popped beat
   pd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_cmd),
      .head_empty (empty),
      .head_pop   (head_pop),
      .out_byte   (rsp_byte),
      .out_last   (rsp_last),
      .out_pop    (pop)
   );

endmodule

`default_nettype wire
